// ----- design/ffha_pkg.sv -----
// Package with shared constants, types and helpers of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

  localparam int HEAP_WORDS = 131072;
  localparam int AW = 18;
  localparam int SW = 17;
  localparam int IW = $clog2(HEAP_WORDS);
  localparam logic [AW-1:0] NIL_LINK = '1;
  localparam logic [AW-1:0] HEAP_LIM = AW'(HEAP_WORDS);
  localparam logic [AW:0] STEP_LIM = (AW+1)'(HEAP_WORDS);

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;
  localparam logic ST_DONE   = 1'b0;
  localparam logic ST_NOSPACE = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [20:0] request_bytes;
    logic [19:0] block_offset;
  } ffha_in_t;

  typedef struct packed {
    logic [19:0] result_offset;
    logic        status;
  } ffha_out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_A_RD, S_A_WT, S_A_CHK, S_A_SPLIT, S_A_HDR, S_A_UNL, S_A_TOP,
    S_F_HEAD, S_F_RD, S_F_WT, S_F_CHK, S_F_INS, S_F_LNK,
    S_M1_RD, S_M1_WT, S_M1_CHK, S_M2_RD, S_M2_WT, S_M2_CHK,
    S_T_RD, S_T_WT, S_T_CHK, S_DONE
  } ffha_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd_it;        // read size and link of it
    logic a_adv;        // alloc walk step
    logic a_split;
    logic a_hdr;        // write the header of the split-off block
    logic a_unlink;
    logic a_top;
    logic a_fail;
    logic f_head;       // insert at head
    logic f_rd;         // read link of it
    logic f_adv;
    logic f_ins;
    logic f_lnk;        // link it to the inserted block
    logic m1_rd;
    logic m1_do;
    logic m2_rd;
    logic m2_do;
    logic t_rd;
    logic t_do;
    logic done;
  } ffha_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic is_free;
    logic it_ok;        // it is a valid word
    logic fit;          // size(it) >= words
    logic split;        // size(it) >= words + 2
    logic steps_ok;
    logic head_first;   // free goes to head of list
    logic p_ok;
    logic f_go;         // free walk continues
    logic m1_hit;
    logic m2_hit;
    logic t_hit;
    logic top_fits;
  } ffha_sts_t;

  function automatic logic ok(input logic [AW-1:0] w);
    return (w != '0) && (w != NIL_LINK) && (w < HEAP_LIM);
  endfunction

endpackage
`default_nettype wire

// ----- design/ffha_ctrl.sv -----
// Controller state machine of the first-fit heap allocator.
`default_nettype none
module ffha_ctrl import ffha_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  ffha_sts_t sts,
  output ffha_cmd_t cmd
);

  ffha_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_A_RD;
      S_A_RD: begin
        if (sts.is_free) state_nxt = sts.p_ok ? S_F_HEAD : S_DONE;
        else if (sts.it_ok) state_nxt = S_A_WT;
        else state_nxt = S_A_TOP;
      end
      S_A_WT: state_nxt = S_A_CHK;
      S_A_CHK: begin
        if (sts.fit) state_nxt = sts.split ? S_A_SPLIT : S_A_UNL;
        else if (!sts.steps_ok) state_nxt = S_A_TOP;
        else state_nxt = S_A_RD;
      end
      S_A_SPLIT: state_nxt = S_A_HDR;
      S_A_HDR, S_A_UNL, S_A_TOP: state_nxt = S_DONE;
      S_F_HEAD: state_nxt = sts.head_first ? S_M1_RD : S_F_RD;
      S_F_RD: state_nxt = S_F_WT;
      S_F_WT: state_nxt = S_F_CHK;
      S_F_CHK: state_nxt = sts.f_go ? S_F_RD : S_F_INS;
      S_F_INS: state_nxt = S_F_LNK;
      S_F_LNK: state_nxt = S_M1_RD;
      S_M1_RD: state_nxt = S_M1_WT;
      S_M1_WT: state_nxt = S_M1_CHK;
      S_M1_CHK: state_nxt = S_M2_RD;
      S_M2_RD: state_nxt = S_M2_WT;
      S_M2_WT: state_nxt = S_M2_CHK;
      S_M2_CHK: state_nxt = S_T_RD;
      S_T_RD: state_nxt = S_T_WT;
      S_T_WT: state_nxt = S_T_CHK;
      S_T_CHK: state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs; read addresses are held through the wait cycle.
  always_comb begin
    cmd = '0;
    busy = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: cmd.load = start;
      S_A_RD: cmd.rd_it = !sts.is_free && sts.it_ok;
      S_A_CHK: begin
        cmd.a_adv = !sts.fit;
      end
      S_A_SPLIT: begin
        cmd.a_split = 1'b1;
      end
      S_A_HDR: cmd.a_hdr = 1'b1;
      S_A_UNL: cmd.a_unlink = 1'b1;
      S_A_TOP: begin
        cmd.a_top = sts.top_fits;
        cmd.a_fail = !sts.top_fits;
      end
      S_F_HEAD: cmd.f_head = 1'b1;
      S_F_RD: cmd.f_rd = 1'b1;
      S_F_CHK: cmd.f_adv = sts.f_go;
      S_F_INS: cmd.f_ins = 1'b1;
      S_F_LNK: cmd.f_lnk = 1'b1;
      S_M1_RD, S_M1_WT: cmd.m1_rd = 1'b1;
      S_M1_CHK: cmd.m1_do = sts.m1_hit;
      S_M2_RD, S_M2_WT: cmd.m2_rd = 1'b1;
      S_M2_CHK: cmd.m2_do = sts.m2_hit;
      S_T_RD, S_T_WT: cmd.t_rd = 1'b1;
      S_T_CHK: cmd.t_do = sts.t_hit;
      S_DONE: cmd.done = 1'b1;
      default: cmd = '0;
    endcase
  end

`ifndef SYNTH
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> busy) else $error("start not taken");
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |=> !busy) else $error("done did not return to idle");
  a_one_alloc_end: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.a_split, cmd.a_unlink, cmd.a_top, cmd.a_fail}) <= 1)
    else $error("two alloc endings at once");
`endif

endmodule
`default_nettype wire

// ----- design/ffha_dp.sv -----
// Datapath of the first-fit heap allocator: header stores, list pointers and arithmetic.
`default_nettype none
module ffha_dp import ffha_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  ffha_in_t  in_item,
  input  ffha_cmd_t cmd,
  output ffha_sts_t sts,
  output ffha_out_t out_item,
  output logic      out_strobe
);

  // Header memories, one write port each; link_mem has one read port, size_mem two.
  logic [SW-1:0] size_mem [HEAP_WORDS];
  logic [AW-1:0] link_mem [HEAP_WORDS];

  logic [AW-1:0] head_r, top_r, it_r, prev_r, p_r, q_r, pred_r, pred2_r, cur_r, res_r;
  logic [AW-1:0] ra_r;
  logic [SW+1:0] words_r;
  logic [SW-1:0] rsz_r, psz_r, csz_r;
  logic [AW-1:0] rlk_r;
  logic [AW:0]   steps_r;
  logic          isfree_r, stat_r, strobe_r;
  logic [19:0]   offs_r;

  logic          sw_en, lw_en;
  logic [AW-1:0] sw_a, lw_a, lw_d;
  logic [SW-1:0] sw_d;
  logic [AW-1:0] rd_a;
  logic [SW+1:0] merge_sum;
  logic [AW+1:0] split_end, top_need;
  logic [SW:0]   rem;
  logic          do_split;

  // Size of the request in words, at least one.
  function automatic logic [SW+1:0] to_words(input logic [20:0] b);
    logic [21:0] t;
    t = {1'b0, b} + 22'd7;
    return (b <= 21'd8) ? (SW+2)'(1) : (SW+2)'(t >> 3);
  endfunction

  // Memory read: address chosen by phase; data registered.
  always_comb begin
    rd_a = it_r;
    if (cmd.m1_rd) rd_a = q_r;
    else if (cmd.m2_rd) rd_a = pred_r;
    else if (cmd.t_rd) rd_a = head_r;
  end

  always_ff @(posedge clk) begin
    rsz_r <= size_mem[rd_a[IW-1:0]];
    rlk_r <= link_mem[rd_a[IW-1:0]];
    ra_r  <= rd_a;
  end

  always_ff @(posedge clk) begin
    if (sw_en) size_mem[sw_a[IW-1:0]] <= sw_d;
    if (lw_en) link_mem[lw_a[IW-1:0]] <= lw_d;
  end

  assign do_split = {2'b0, rsz_r} >= words_r + 19'd2;
  assign rem = {1'b0, rsz_r} - {1'b0, words_r[SW-1:0]} - 18'd1;
  assign split_end = {2'b0, it_r} + {3'b0, rem[SW-1:0]} + 20'd1;
  assign top_need = {2'b0, top_r} + {1'b0, words_r} + 20'd1;

  // Status toward the controller.
  always_comb begin
    sts = '0;
    sts.is_free   = isfree_r;
    sts.it_ok     = ok(it_r);
    sts.fit       = {2'b0, rsz_r} >= words_r;
    sts.split     = do_split;
    sts.steps_ok  = steps_r < STEP_LIM;
    sts.head_first = !ok(head_r) || (p_r > head_r);
    sts.p_ok      = ok(p_r);
    sts.f_go      = ok(rlk_r) && (rlk_r > p_r) && (steps_r < STEP_LIM);
    sts.m1_hit    = ok(ra_r) && ({2'b0, ra_r} + {3'b0, rsz_r} + 20'd1 == {2'b0, p_r});
    sts.m2_hit    = ok(pred_r) && ({2'b0, cur_r} + {3'b0, csz_r} + 20'd1 == {2'b0, pred_r});
    sts.t_hit     = ok(head_r) && ({1'b0, head_r} + {2'b0, rsz_r} == {1'b0, top_r});
    sts.top_fits  = top_r <= HEAP_LIM &&
                    ({1'b0, words_r} + 20'd1 <= {2'b0, HEAP_LIM - top_r});
  end

  assign merge_sum = {2'b0, rsz_r} + {2'b0, psz_r} + 19'd1;

  // Store writes.
  always_comb begin
    sw_en = 1'b0; sw_a = it_r; sw_d = '0;
    lw_en = 1'b0; lw_a = p_r;  lw_d = head_r;
    if (cmd.a_split) begin
      sw_en = 1'b1; sw_a = it_r; sw_d = rem[SW-1:0];
    end
    if (cmd.a_hdr) begin
      sw_en = res_r < HEAP_LIM; sw_a = res_r; sw_d = words_r[SW-1:0];
    end
    if (cmd.a_unlink) begin
      lw_en = ok(prev_r); lw_a = prev_r; lw_d = rlk_r;
    end
    if (cmd.a_top) begin
      sw_en = 1'b1; sw_a = top_r + 18'd1; sw_d = words_r[SW-1:0];
    end
    if (cmd.f_head) begin
      lw_en = !ok(head_r) || p_r > head_r;
      lw_a = p_r; lw_d = head_r;
    end
    if (cmd.f_ins) begin
      lw_en = 1'b1; lw_a = p_r; lw_d = rlk_r;
    end
    if (cmd.f_lnk) begin
      lw_en = 1'b1; lw_a = it_r; lw_d = p_r;
    end
    if (cmd.m1_do) begin
      sw_en = 1'b1; sw_a = ra_r; sw_d = merge_sum[SW-1:0];
      lw_en = ok(pred_r); lw_a = pred_r; lw_d = ra_r;
    end
    if (cmd.m2_do) begin
      sw_en = 1'b1; sw_a = cur_r;
      sw_d = SW'({2'b0, csz_r} + {2'b0, rsz_r} + 19'd1);
      lw_en = ok(pred2_r); lw_a = pred2_r; lw_d = cur_r;
    end
  end

  // Control registers and pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NIL_LINK;
      top_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.done;
      if (cmd.a_unlink && !ok(prev_r)) head_r <= rlk_r;
      if (cmd.a_top) top_r <= top_need[AW-1:0];
      if (cmd.f_head && (!ok(head_r) || p_r > head_r)) head_r <= p_r;
      if (cmd.m1_do && !ok(pred_r)) head_r <= ra_r;
      if (cmd.m2_do && !ok(pred2_r)) head_r <= cur_r;
      if (cmd.t_do) begin
        top_r <= head_r - 18'd1;
        head_r <= rlk_r;
      end
    end
  end

  // Walk pointers and results.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      isfree_r <= in_item.req_type == REQ_FREE;
      words_r <= to_words(in_item.request_bytes);
      p_r <= {1'b0, in_item.block_offset[19:3]};
      cur_r <= {1'b0, in_item.block_offset[19:3]};
      it_r <= head_r;
      prev_r <= NIL_LINK;
      pred_r <= NIL_LINK;
      pred2_r <= NIL_LINK;
      steps_r <= '0;
      res_r <= '0;
      stat_r <= ST_DONE;
    end
    if (cmd.a_adv) begin
      prev_r <= it_r; it_r <= rlk_r; steps_r <= steps_r + 1'b1;
    end
    if (cmd.a_split) res_r <= split_end[AW-1:0];
    if (cmd.a_unlink) res_r <= it_r;
    if (cmd.a_top) res_r <= top_r + 18'd1;
    if (cmd.a_fail) stat_r <= ST_NOSPACE;
    if (cmd.f_head) begin
      q_r <= head_r;
      it_r <= head_r;
    end
    if (cmd.f_adv) begin
      pred2_r <= it_r; it_r <= rlk_r; steps_r <= steps_r + 1'b1;
    end
    if (cmd.f_ins) begin
      pred_r <= it_r;
      q_r <= rlk_r;
    end
    // The freed block's size, and the size of cur ahead of the second merge.
    if (cmd.m1_rd) begin
      psz_r <= size_mem[p_r[IW-1:0]];
      csz_r <= size_mem[p_r[IW-1:0]];
    end
    if (cmd.m1_do) begin
      cur_r <= ra_r;
      csz_r <= merge_sum[SW-1:0];
    end
    offs_r <= {res_r[16:0], 3'b000};
  end

  assign out_strobe = strobe_r;
  assign out_item.result_offset = offs_r;
  assign out_item.status = stat_r;

endmodule
`default_nettype wire

// ----- design/first_fit_heap_allocator.sv -----
// Top level of the first-fit heap allocator.
// Usage: raise start with in_item while busy is low; the item is taken at that
// edge. Allocate requests walk the address-sorted free list for the first
// block that fits, splitting it from its tail or taking it whole, and carve
// from the unused top when nothing fits. Free requests insert the block in
// order, merge it with free neighbors and give the top block back to the
// unused region. One result comes per item on out_item, marked by out_valid
// for one cycle; the receiver cannot stall it.
// The result is shown after the walk over the free list in the header
// memories and, for a free, after the insert, merge and trim steps.
// Throughput: one item at a time; busy falls in the cycle the result is shown,
// and the next item can be taken at the end of that cycle.
// Reset leaves the heap empty and the free list empty; header memories need
// no clearing.
`default_nettype none
module first_fit_heap_allocator import ffha_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  ffha_in_t  in_item,
  output ffha_out_t out_item,
  output logic      out_valid
);

  ffha_cmd_t cmd;
  ffha_sts_t sts;

  ffha_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .sts, .cmd);
  ffha_dp u_dp (.clk, .rst_n, .in_item, .cmd, .sts, .out_item, .out_strobe(out_valid));

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the first-fit heap allocator.
`timescale 1ns / 100ps
module testbench;
  import ffha_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int unsigned NIL = 32'h3FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  ffha_in_t in_item = '0;
  ffha_out_t out_item;
  logic out_valid;

  first_fit_heap_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_item(out_item), .out_valid(out_valid)
  );

  always #1 clk = ~clk;

  // Shadow copy of the heap headers.
  logic [SW-1:0] hdr_size [HEAP_WORDS];
  logic [AW-1:0] hdr_link [HEAP_WORDS];
  int unsigned shadow_top;
  int unsigned shadow_head;

  ffha_out_t grant_queue[$];
  logic [19:0] live_blocks[$];
  int mismatches = 0;
  int idle_cycles = 0;

  function automatic bit word_ok(int unsigned w);
    return w != 0 && w != NIL && w < HEAP_WORDS;
  endfunction

  // Predicts the grant for one allocation and updates the shadow heap.
  function automatic ffha_out_t predict_alloc(logic [20:0] bytes);
    ffha_out_t r;
    int unsigned words, it, prev, steps, sz, p;
    r = '0;
    words = (bytes <= 8) ? 1 : (int'(bytes) + 7) >> 3;
    it = shadow_head;
    prev = NIL;
    steps = 0;
    while (word_ok(it) && hdr_size[it] < words && steps < HEAP_WORDS) begin
      prev = it;
      it = hdr_link[it];
      steps++;
    end
    if (word_ok(it) && hdr_size[it] >= words) begin
      sz = hdr_size[it];
      if (sz >= words + 2) begin
        // Split from the tail of the free block.
        sz -= words + 1;
        hdr_size[it] = sz[SW-1:0];
        p = it + sz + 1;
        if (p < HEAP_WORDS) hdr_size[p] = words[SW-1:0];
      end else begin
        if (word_ok(prev)) hdr_link[prev] = hdr_link[it];
        else shadow_head = hdr_link[it];
        p = it;
      end
    end else if (words + 1 <= HEAP_WORDS - shadow_top) begin
      p = shadow_top + 1;
      shadow_top += words + 1;
      hdr_size[p] = words[SW-1:0];
    end else begin
      p = 0;
      r.status = ST_NOSPACE;
    end
    r.result_offset = 20'(p << 3);
    return r;
  endfunction

  // Inserts a freed block, merges neighbors and trims the top.
  function automatic void predict_free(logic [19:0] offset);
    int unsigned p, pred, pred2, cur, q, h, it, steps;
    p = offset >> 3;
    pred = NIL;
    pred2 = NIL;
    cur = p;
    if (!word_ok(p)) return;
    if (!word_ok(shadow_head) || p > shadow_head) begin
      hdr_link[p] = shadow_head[AW-1:0];
      shadow_head = p;
    end else begin
      it = shadow_head;
      steps = 0;
      while (word_ok(hdr_link[it]) && hdr_link[it] > p && steps < HEAP_WORDS) begin
        pred2 = it;
        it = hdr_link[it];
        steps++;
      end
      hdr_link[p] = hdr_link[it];
      hdr_link[it] = p[AW-1:0];
      pred = it;
    end
    q = hdr_link[p];
    if (word_ok(q) && q + hdr_size[q] + 1 == p) begin
      hdr_size[q] = SW'(hdr_size[q] + hdr_size[p] + 1);
      if (word_ok(pred)) hdr_link[pred] = q[AW-1:0];
      else shadow_head = q;
      cur = q;
    end
    if (word_ok(pred) && cur + hdr_size[cur] + 1 == pred) begin
      hdr_size[cur] = SW'(hdr_size[cur] + hdr_size[pred] + 1);
      if (word_ok(pred2)) hdr_link[pred2] = cur[AW-1:0];
      else shadow_head = cur;
    end
    h = shadow_head;
    if (word_ok(h) && h + hdr_size[h] == shadow_top) begin
      shadow_top = h - 1;
      shadow_head = hdr_link[h];
    end
  endfunction

  // Offers one item, waits for it to be taken, then records what it should give.
  task automatic issue_item(ffha_in_t item, int gap, bit typed, ffha_out_t typed_res);
    ffha_out_t res;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    if (item.req_type == REQ_ALLOC) begin
      res = predict_alloc(item.request_bytes);
      if (res.status == ST_DONE) live_blocks.push_back(res.result_offset);
    end else begin
      predict_free(item.block_offset);
      res = '0;
      for (int k = 0; k < live_blocks.size(); k++)
        if (live_blocks[k] == {item.block_offset[19:3], 3'b000}) begin
          live_blocks.delete(k);
          break;
        end
    end
    grant_queue.push_back(typed ? typed_res : res);
  endtask

  // Compares each result with the oldest pending one.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (grant_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", out_item);
      end else begin
        if (out_item.result_offset !== grant_queue[0].result_offset ||
            out_item.status !== grant_queue[0].status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected offset %h status %b, got offset %h status %b",
                     grant_queue[0].result_offset, grant_queue[0].status,
                     out_item.result_offset, out_item.status);
        end
        void'(grant_queue.pop_front());
      end
    end
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  typedef struct {
    logic        req;
    int          bytes;
    int          offset;
    bit          from_live;
    bit          typed;
    ffha_out_t   res;
  } stim_row_t;

  stim_row_t directed_rows[] = '{
    '{REQ_ALLOC, 0,       0,  0, 1, '{20'd8,  ST_DONE}},
    '{REQ_ALLOC, 1048576, 0,  0, 1, '{20'd0,  ST_NOSPACE}},
    '{REQ_ALLOC, 8,       0,  0, 1, '{20'd24, ST_DONE}},
    '{REQ_ALLOC, 9,       0,  0, 1, '{20'd40, ST_DONE}},
    '{REQ_FREE,  0,       7,  0, 1, '{20'd0,  ST_DONE}},
    '{REQ_FREE,  0,       15, 0, 1, '{20'd0,  ST_DONE}},
    '{REQ_ALLOC, 2040,    0,  0, 1, '{20'd64, ST_DONE}},
    '{REQ_FREE,  0,       40, 0, 1, '{20'd0,  ST_DONE}},
    '{REQ_FREE,  0,       24, 0, 1, '{20'd0,  ST_DONE}},
    '{REQ_ALLOC, 24,      0,  0, 0, '{20'd0,  ST_DONE}},
    '{REQ_ALLOC, 1048575, 0,  0, 1, '{20'd0,  ST_NOSPACE}},
    '{REQ_ALLOC, 1040000, 0,  0, 0, '{20'd0,  ST_DONE}},
    '{REQ_ALLOC, 4000,    0,  0, 0, '{20'd0,  ST_DONE}},
    '{REQ_ALLOC, 1048576, 0,  0, 1, '{20'd0,  ST_NOSPACE}},
    '{REQ_ALLOC, 16,      0,  0, 0, '{20'd0,  ST_DONE}},
    '{REQ_FREE,  0,       0,  1, 0, '{20'd0,  ST_DONE}},
    '{REQ_FREE,  0,       0,  1, 0, '{20'd0,  ST_DONE}},
    '{REQ_ALLOC, 7,       0,  0, 0, '{20'd0,  ST_DONE}},
    '{REQ_FREE,  0,       0,  1, 0, '{20'd0,  ST_DONE}},
    '{REQ_FREE,  0,       0,  1, 0, '{20'd0,  ST_DONE}},
    '{REQ_ALLOC, 1,       0,  0, 0, '{20'd0,  ST_DONE}}
  };

  initial begin
    ffha_in_t item;
    int gap, pick, idle_pct;
    shadow_top = 0;
    shadow_head = NIL;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: extremes, no-space, ignored frees and merges.
    foreach (directed_rows[i]) begin
      item = '0;
      item.req_type = directed_rows[i].req;
      item.request_bytes = 21'(directed_rows[i].bytes);
      item.block_offset = directed_rows[i].from_live ?
          (live_blocks[$] | 20'($urandom_range(0, 7))) : 20'(directed_rows[i].offset);
      issue_item(item, 0, directed_rows[i].typed, directed_rows[i].res);
    end

    // Random part in phases of sender idling.
    for (int n = 0; n < 2000; n++) begin
      case ((n / 250) % 4)
        0: idle_pct = 0;
        1: idle_pct = 74;
        2: idle_pct = 0;
        default: idle_pct = 13;
      endcase
      if (n == 1000) begin
        // Let the block drain completely once.
        start <= 1'b0;
        while (grant_queue.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      gap = ($urandom_range(1, 100) <= idle_pct) ? $urandom_range(1, 6) : 0;
      item = '0;
      item.request_bytes = 21'($urandom);
      item.block_offset = 20'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        // Free of word zero, ignored.
        item.req_type = REQ_FREE;
        item.block_offset = 20'($urandom_range(0, 7));
      end else if (live_blocks.size() > 0 &&
                   (pick < 45 || live_blocks.size() > 300)) begin
        item.req_type = REQ_FREE;
        item.block_offset = live_blocks[$urandom_range(0, live_blocks.size() - 1)] |
                            20'($urandom_range(0, 7));
      end else begin
        item.req_type = REQ_ALLOC;
        if (pick > 98) item.request_bytes = 21'($urandom_range(0, 1048576));
        else if (pick > 94) item.request_bytes = 21'($urandom_range(0, 20000));
        else item.request_bytes = 21'($urandom_range(0, 300));
      end
      issue_item(item, gap, 0, '0);
    end
    start <= 1'b0;

    while (grant_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ffha_pkg.sv
design/ffha_ctrl.sv
design/ffha_dp.sv
design/first_fit_heap_allocator.sv
verif/testbench.sv
